[hdl/stx_pkg.sv]
// Shared types, codes and reset values of the framed packet receiver.
// No dependencies; every other file of the block but stx_ifs.sv imports this package.
`default_nettype none

package stx_pkg;

	// Result status codes
	typedef enum logic [2:0] {
		ST_MEAS_OK  = 3'd0,
		ST_STATE_OK = 3'd1,
		ST_BAD_END  = 3'd2,
		ST_BAD_CHK  = 3'd3,
		ST_TIMEOUT  = 3'd4,
		ST_UNKNOWN  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		MODE_STANDBY = 2'd0,
		MODE_PURGE   = 2'd1,
		MODE_MEASURE = 2'd2
	} mode_t;

	// Configuration register indexes
	localparam logic [2:0] REG_MEAS_START  = 3'd0;
	localparam logic [2:0] REG_MEAS_END    = 3'd1;
	localparam logic [2:0] REG_STATE_START = 3'd2;
	localparam logic [2:0] REG_STATE_END   = 3'd3;
	localparam logic [2:0] REG_MEAS_LEN    = 3'd4;
	localparam logic [2:0] REG_STATE_LEN   = 3'd5;
	localparam logic [2:0] REG_TIMEOUT     = 3'd6;

	// Reset values of the registers
	localparam logic [7:0]  RST_MEAS_START  = 8'd147;
	localparam logic [7:0]  RST_MEAS_END    = 8'd3;
	localparam logic [7:0]  RST_STATE_START = 8'd148;
	localparam logic [7:0]  RST_STATE_END   = 8'd4;
	localparam logic [6:0]  RST_MEAS_LEN    = 7'd18;
	localparam logic [6:0]  RST_STATE_LEN   = 7'd24;
	localparam logic [15:0] RST_TIMEOUT     = 16'd1000;

	// Measure frame payload: bytes 1 to 14
	localparam int NUM_FIELD_BYTES = 14;

	typedef struct packed {
		logic [7:0]  meas_start;
		logic [7:0]  meas_end;
		logic [7:0]  state_start;
		logic [7:0]  state_end;
		logic [6:0]  meas_len;
		logic [6:0]  state_len;
		logic [15:0] timeout;
	} cfg_t;

	// Stage 1 contents: verdict so far plus what the checksum and decode need
	typedef struct packed {
		status_t                               pre;
		logic                                  chk;
		logic                                  is_state;
		logic [7:0]                            sum_neg;
		logic [7:0]                            chk_byte;
		logic [NUM_FIELD_BYTES-1:0][7:0]       fld;
	} s1_t;

	typedef struct packed {
		status_t            status;
		mode_t              mode;
		logic [15:0]        sec;
		logic [15:0]        c_small;
		logic [15:0]        c_mid;
		logic [15:0]        c_large;
		logic signed [15:0] temp;
		logic [15:0]        pres;
		logic [7:0]         batt;
		logic [7:0]         hum;
	} res_t;

endpackage

`default_nettype wire

[hdl/stx_ifs.sv]
// Channel interfaces of the framed packet receiver: input items, results,
// configuration writes. No dependencies.
`default_nettype none

interface stx_rx_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] byte_value;
	modport source (output valid, action, byte_value, input ready);
	modport sink   (input valid, action, byte_value, output ready);
endinterface

interface stx_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [1:0]         device_mode;
	logic [15:0]        elapsed_sec;
	logic [15:0]        count_small;
	logic [15:0]        count_mid;
	logic [15:0]        count_large;
	logic signed [15:0] temperature;
	logic [15:0]        pressure;
	logic [7:0]         battery;
	logic [7:0]         humidity;
	modport source (output valid, status, device_mode, elapsed_sec, count_small, count_mid,
		count_large, temperature, pressure, battery, humidity, input ready);
	modport sink   (input valid, status, device_mode, elapsed_sec, count_small, count_mid,
		count_large, temperature, pressure, battery, humidity, output ready);
endinterface

interface stx_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/stx_etx_frame_receiver.sv]
// Result path: the stage 1 register loads at the edge that accepts a byte or tick,
// and the output register then takes the result from it and shows it on res.
// Throughput: one item per cycle; rx.ready drops only while both the stage 1
// and output registers hold results and res.ready is low.
// Reset: arst_n clears the frame state, valid flags and configuration registers;
// the frame byte memory has no reset and needs no clearing pass.
`default_nettype none

module stx_etx_frame_receiver #(
	parameter int MAX_FRAME = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	stx_rx_if.sink    rx,
	stx_res_if.source res,
	stx_cfg_if.sink   cfg
);
	import stx_pkg::*;

	cfg_t regs;
	s1_t  s1;
	logic s1_valid;
	logic s1_take;

	// Hold the configuration; writes are registered and always taken
	stx_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Track hunting/collecting, store frame bytes, count ticks, advance the sum.
	// Every transaction on rx updates the frame state in the cycle it is taken.
	stx_frame_track #(
		.MAX_FRAME (MAX_FRAME)
	) u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.regs     (regs),
		.s1_take  (s1_take),
		.s1_valid (s1_valid),
		.s1       (s1)
	);

	// Settle the checksum, decode measure fields and hold the result until taken
	stx_result_stage u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (s1_valid),
		.s1       (s1),
		.s1_take  (s1_take),
		.res      (res)
	);

endmodule

`default_nettype wire

[hdl/stx_cfg_regs.sv]
// Configuration register file of the framed packet receiver.
// Depends on stx_pkg and stx_cfg_if.
`default_nettype none

module stx_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	stx_cfg_if.sink           cfg,
	output stx_pkg::cfg_t     regs
);
	import stx_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.meas_start  <= RST_MEAS_START;
			regs_q.meas_end    <= RST_MEAS_END;
			regs_q.state_start <= RST_STATE_START;
			regs_q.state_end   <= RST_STATE_END;
			regs_q.meas_len    <= RST_MEAS_LEN;
			regs_q.state_len   <= RST_STATE_LEN;
			regs_q.timeout     <= RST_TIMEOUT;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MEAS_START:  regs_q.meas_start  <= cfg.data[7:0];
				REG_MEAS_END:    regs_q.meas_end    <= cfg.data[7:0];
				REG_STATE_START: regs_q.state_start <= cfg.data[7:0];
				REG_STATE_END:   regs_q.state_end   <= cfg.data[7:0];
				REG_MEAS_LEN:    regs_q.meas_len    <= cfg.data[6:0];
				REG_STATE_LEN:   regs_q.state_len   <= cfg.data[6:0];
				REG_TIMEOUT:     regs_q.timeout     <= cfg.data;
				default:         ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/stx_frame_track.sv]
// Frame tracker: hunting and collecting state, frame byte memory, running sum
// and timeout counter; loads the stage 1 register. Depends on stx_pkg, stx_rx_if.
`default_nettype none

module stx_frame_track #(
	parameter int MAX_FRAME = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	stx_rx_if.sink            rx,
	input  wire stx_pkg::cfg_t regs,
	input  wire logic         s1_take,
	output logic              s1_valid,
	output stx_pkg::s1_t      s1
);
	import stx_pkg::*;

	localparam int AW  = $clog2(MAX_FRAME);
	localparam int LW0 = $clog2(MAX_FRAME + 1);
	localparam int CW  = (LW0 > 7 ? LW0 : 7) + 1;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_FRAME);
	localparam logic [CW-1:0] LEN_MIN = CW'(4);

	logic          col_q;
	logic          is_state_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   el_q;
	logic [7:0]    sum_q;
	logic [7:0]    fb_q [NUM_FIELD_BYTES];
	logic [7:0]    mem [MAX_FRAME];

	logic          s1_valid_q;
	s1_t           s1_q;

	logic          acc;
	logic [CW-1:0] len_raw;
	logic [CW-1:0] len;
	logic [CW-1:0] idx_w;
	logic [7:0]    endc;
	logic [15:0]   limit;
	logic [15:0]   el_inc;
	logic [AW-1:0] rd_addr;
	logic          wr_en;

	logic          col_d;
	logic          is_state_d;
	logic [AW-1:0] idx_d;
	logic [15:0]   el_d;
	logic [7:0]    sum_d;
	logic          res_d;
	status_t       pre_d;
	logic          chk_d;
	logic [NUM_FIELD_BYTES-1:0][7:0] fld_d;

	assign acc      = rx.valid & s1_take;
	assign rx.ready = s1_take;
	assign s1_valid = s1_valid_q;
	assign s1       = s1_q;

	always_comb begin
		len_raw = is_state_q ? CW'(regs.state_len) : CW'(regs.meas_len);
		if (len_raw < LEN_MIN)
			len = LEN_MIN;
		else if (len_raw > LEN_MAX)
			len = LEN_MAX;
		else
			len = len_raw;
	end

	assign endc    = is_state_q ? regs.state_end : regs.meas_end;
	assign idx_w   = CW'(idx_q);
	assign limit   = (regs.timeout == 16'd0) ? 16'd1 : regs.timeout;
	assign el_inc  = (el_q == 16'hFFFF) ? el_q : el_q + 16'd1;
	assign rd_addr = AW'(len - CW'(2));
	assign wr_en   = acc & ~rx.action & col_q;

	// Next frame state and verdict for the accepted item
	always_comb begin
		col_d      = col_q;
		is_state_d = is_state_q;
		idx_d      = idx_q;
		el_d       = el_q;
		sum_d      = sum_q;
		res_d      = 1'b0;
		pre_d      = ST_BAD_END;
		chk_d      = 1'b0;
		if (rx.action) begin
			if (col_q) begin
				el_d = el_inc;
				if (el_inc >= limit) begin
					res_d = 1'b1;
					pre_d = ST_TIMEOUT;
				end
			end
		end else if (!col_q) begin
			if (rx.byte_value == regs.meas_start || rx.byte_value == regs.state_start) begin
				col_d      = 1'b1;
				is_state_d = (rx.byte_value != regs.meas_start);
				idx_d      = AW'(1);
				el_d       = 16'd0;
				sum_d      = 8'd0;
			end else begin
				res_d = 1'b1;
				pre_d = ST_UNKNOWN;
			end
		end else begin
			if (idx_w + CW'(3) <= len)
				sum_d = sum_q + rx.byte_value;
			if (idx_w + CW'(1) < len) begin
				idx_d = idx_q + AW'(1);
			end else begin
				res_d = 1'b1;
				if (rx.byte_value != endc)
					pre_d = ST_BAD_END;
				else
					chk_d = 1'b1;
			end
		end
		// Any result ends the frame: go back to hunting
		if (res_d) begin
			col_d      = 1'b0;
			is_state_d = 1'b0;
			idx_d      = '0;
			el_d       = 16'd0;
		end
	end

	// Field bytes, with the byte on the port bypassed and positions past the end zeroed
	always_comb begin
		for (int i = 0; i < NUM_FIELD_BYTES; i++) begin
			if (CW'(i + 1) >= len)
				fld_d[i] = 8'd0;
			else if (idx_w == CW'(i + 1))
				fld_d[i] = rx.byte_value;
			else
				fld_d[i] = fb_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= 1'b0;
			is_state_q <= 1'b0;
			idx_q      <= '0;
			el_q       <= 16'd0;
			sum_q      <= 8'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				col_q      <= col_d;
				is_state_q <= is_state_d;
				idx_q      <= idx_d;
				el_q       <= el_d;
				sum_q      <= res_d ? 8'd0 : sum_d;
			end
			if (s1_take)
				s1_valid_q <= acc & res_d;
		end
	end

	// Frame byte store and captured field bytes
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_q] <= rx.byte_value;
		for (int i = 0; i < NUM_FIELD_BYTES; i++) begin
			if (wr_en && idx_w == CW'(i + 1))
				fb_q[i] <= rx.byte_value;
		end
	end

	// Stage 1 payload; the checksum byte comes from the registered memory read
	always_ff @(posedge clk) begin
		if (s1_take) begin
			s1_q.pre      <= pre_d;
			s1_q.chk      <= chk_d;
			s1_q.is_state <= is_state_q;
			s1_q.sum_neg  <= 8'd0 - sum_d;
			s1_q.chk_byte <= mem[rd_addr];
			s1_q.fld      <= fld_d;
		end
	end

endmodule

`default_nettype wire

[hdl/stx_result_stage.sv]
// Result stage: checksum verdict, measure field decode and the output register.
// Depends on stx_pkg and stx_res_if.
`default_nettype none

module stx_result_stage (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s1_valid,
	input  wire stx_pkg::s1_t s1,
	output logic             s1_take,
	stx_res_if.source        res
);
	import stx_pkg::*;

	logic    o_valid_q;
	res_t    o_q;
	res_t    r_d;
	logic    o_take;
	status_t st;

	assign o_take  = ~o_valid_q | res.ready;
	assign s1_take = ~s1_valid | o_take;

	always_comb begin
		if (!s1.chk)
			st = s1.pre;
		else if (s1.chk_byte != s1.sum_neg)
			st = ST_BAD_CHK;
		else if (s1.is_state)
			st = ST_STATE_OK;
		else
			st = ST_MEAS_OK;

		r_d = '0;
		r_d.status = st;
		if (st == ST_MEAS_OK) begin
			r_d.sec     = {s1.fld[0], s1.fld[1]};
			r_d.c_small = {s1.fld[2], s1.fld[3]};
			r_d.c_mid   = {s1.fld[4], s1.fld[5]};
			r_d.c_large = {s1.fld[6], s1.fld[7]};
			r_d.temp    = {s1.fld[8], s1.fld[9]};
			r_d.pres    = {s1.fld[10], s1.fld[11]};
			r_d.batt    = s1.fld[12];
			r_d.hum     = s1.fld[13];
			if (r_d.sec != 16'd0)
				r_d.mode = MODE_MEASURE;
			else if (r_d.c_small == 16'd0 && r_d.c_mid == 16'd0 && r_d.c_large == 16'd0)
				r_d.mode = MODE_STANDBY;
			else
				r_d.mode = MODE_PURGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (o_take)
			o_valid_q <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (o_take)
			o_q <= r_d;
	end

	assign res.valid       = o_valid_q;
	assign res.status      = o_q.status;
	assign res.device_mode = o_q.mode;
	assign res.elapsed_sec = o_q.sec;
	assign res.count_small = o_q.c_small;
	assign res.count_mid   = o_q.c_mid;
	assign res.count_large = o_q.c_large;
	assign res.temperature = o_q.temp;
	assign res.pressure    = o_q.pres;
	assign res.battery     = o_q.batt;
	assign res.humidity    = o_q.hum;

endmodule

`default_nettype wire

[hdl/stx_checker.sv]
// Port-level checker of the framed packet receiver and its bind to the top level.
// Depends on stx_pkg.
`default_nettype none

module stx_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  status,
	input wire logic [1:0]  device_mode,
	input wire logic [15:0] elapsed_sec,
	input wire logic [15:0] count_small,
	input wire logic [7:0]  battery
);
	import stx_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status))
		else $error("result dropped or changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status <= ST_UNKNOWN)
		else $error("undefined status code");

	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != ST_MEAS_OK |->
		device_mode == MODE_STANDBY && elapsed_sec == 16'd0 && count_small == 16'd0 &&
		battery == 8'd0)
		else $error("fields not cleared on non-measure result");

	a_mode_sec: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_MEAS_OK |->
		(elapsed_sec != 16'd0) == (device_mode == MODE_MEASURE))
		else $error("device mode disagrees with seconds field");

endmodule

bind stx_etx_frame_receiver stx_checker u_stx_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.status      (res.status),
	.device_mode (res.device_mode),
	.elapsed_sec (res.elapsed_sec),
	.count_small (res.count_small),
	.battery     (res.battery)
);

`default_nettype wire

[dv/stx_frame_monitor.sv]
`timescale 1ns / 1ps
// Result checking for the framed packet receiver: tracks configuration writes,
// forecasts every result from accepted bytes and ticks, and compares each one.
// Depends on stx_pkg and the channel interfaces in stx_ifs.sv.

module stx_frame_monitor
	import stx_pkg::*;
#(
	parameter int MAX_FRAME = 64
) (
	input  logic clk,
	input  logic arst_n,
	stx_rx_if    rx,
	stx_res_if   res,
	stx_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	logic [7:0]  meas_start, meas_end, state_start, state_end;
	logic [6:0]  meas_len, state_len;
	logic [15:0] tick_limit;

	logic        in_frame;
	logic        frame_state;
	logic [6:0]  pos;
	logic [15:0] ticks;
	logic [7:0]  csum;
	logic [7:0]  frame_mem [MAX_FRAME];

	res_t        due_results [$];
	int          mismatches = 0;
	int          due_count = 0;

	assign fail_count = mismatches;
	assign pending    = due_count;

	function automatic int clamp_len(input logic [6:0] v);
		if (v < 7'd4)
			return 4;
		if (int'(v) > MAX_FRAME)
			return MAX_FRAME;
		return int'(v);
	endfunction

	// Bytes past the frame end read as zero
	function automatic logic [7:0] byte_at(input int i, input int len);
		if (i >= len || i >= MAX_FRAME)
			return 8'h00;
		return frame_mem[i];
	endfunction

	function automatic logic [15:0] word_at(input int i, input int len);
		return {byte_at(i, len), byte_at(i + 1, len)};
	endfunction

	function automatic void back_to_hunt();
		in_frame    = 1'b0;
		frame_state = 1'b0;
		pos         = 7'd0;
		ticks       = 16'd0;
		csum        = 8'd0;
	endfunction

	// Advance the frame tracker by one byte or tick; return 1 with the result in r
	// when the item finishes something.
	function automatic bit frame_step(input logic act, input logic [7:0] b, output res_t r);
		int          len;
		logic [7:0]  endc;
		logic [15:0] lim;
		r = '0;
		if (act) begin
			lim = (tick_limit == 16'd0) ? 16'd1 : tick_limit;
			if (!in_frame)
				return 1'b0;
			if (ticks != 16'hFFFF)
				ticks = ticks + 16'd1;
			if (ticks < lim)
				return 1'b0;
			back_to_hunt();
			r.status = ST_TIMEOUT;
			return 1'b1;
		end
		if (!in_frame) begin
			if (b == meas_start || b == state_start) begin
				in_frame     = 1'b1;
				frame_state  = (b != meas_start);
				frame_mem[0] = b;
				pos          = 7'd1;
				ticks        = 16'd0;
				csum         = 8'd0;
				return 1'b0;
			end
			r.status = ST_UNKNOWN;
			return 1'b1;
		end
		len  = clamp_len(frame_state ? state_len : meas_len);
		endc = frame_state ? state_end : meas_end;
		if (int'(pos) < MAX_FRAME)
			frame_mem[pos] = b;
		if (pos >= 7'd1 && int'(pos) + 3 <= len)
			csum = csum + b;
		if (int'(pos) + 1 < len) begin
			pos = pos + 7'd1;
			return 1'b0;
		end
		if (b != endc)
			r.status = ST_BAD_END;
		else if (8'(8'd0 - csum) != byte_at(len - 2, len))
			r.status = ST_BAD_CHK;
		else if (frame_state)
			r.status = ST_STATE_OK;
		else begin
			r.status  = ST_MEAS_OK;
			r.sec     = word_at(1, len);
			r.c_small = word_at(3, len);
			r.c_mid   = word_at(5, len);
			r.c_large = word_at(7, len);
			r.temp    = word_at(9, len);
			r.pres    = word_at(11, len);
			r.batt    = byte_at(13, len);
			r.hum     = byte_at(14, len);
			if (r.sec != 16'd0)
				r.mode = MODE_MEASURE;
			else if (r.c_small == 16'd0 && r.c_mid == 16'd0 && r.c_large == 16'd0)
				r.mode = MODE_STANDBY;
			else
				r.mode = MODE_PURGE;
		end
		back_to_hunt();
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			meas_start  = RST_MEAS_START;
			meas_end    = RST_MEAS_END;
			state_start = RST_STATE_START;
			state_end   = RST_STATE_END;
			meas_len    = RST_MEAS_LEN;
			state_len   = RST_STATE_LEN;
			tick_limit  = RST_TIMEOUT;
			back_to_hunt();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MEAS_START:  meas_start  = cfg.data[7:0];
					REG_MEAS_END:    meas_end    = cfg.data[7:0];
					REG_STATE_START: state_start = cfg.data[7:0];
					REG_STATE_END:   state_end   = cfg.data[7:0];
					REG_MEAS_LEN:    meas_len    = cfg.data[6:0];
					REG_STATE_LEN:   state_len   = cfg.data[6:0];
					REG_TIMEOUT:     tick_limit  = cfg.data;
					default: ;
				endcase
			end
			if (rx.valid && rx.ready) begin
				if (frame_step(rx.action, rx.byte_value, want))
					due_results.push_back(want);
			end
			if (res.valid && res.ready) begin
				if (due_results.size() == 0) begin
					$error("result with nothing outstanding, status %0d", res.status);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, res.status);
					check_field("device_mode", want.mode, res.device_mode);
					check_field("elapsed_sec", want.sec, res.elapsed_sec);
					check_field("count_small", want.c_small, res.count_small);
					check_field("count_mid", want.c_mid, res.count_mid);
					check_field("count_large", want.c_large, res.count_large);
					check_field("temperature", want.temp, res.temperature);
					check_field("pressure", want.pres, res.pressure);
					check_field("battery", want.batt, res.battery);
					check_field("humidity", want.hum, res.humidity);
				end
			end
			due_count = due_results.size();
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the framed packet receiver bench: clock, reset, stimulus and verdict.
// Depends on stx_pkg, stx_ifs.sv, stx_frame_monitor and the receiver itself.

module testbench;
	import stx_pkg::*;

	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 5;
	localparam int LATENCY      = 2;     // byte in to result out
	localparam int MAX_FRAME    = 64;
	localparam int STILL_LIMIT  = 2000;  // idle cycles before the run is declared hung
	localparam int TICK_RUN_MAX = 300;   // longest tick run used to force a timeout

	typedef enum int {FR_GOOD, FR_BAD_END, FR_BAD_SUM, FR_CUT} frame_fault_t;

	logic clk = 1'b0;
	logic arst_n;

	stx_rx_if  rx_ch ();
	stx_res_if res_ch ();
	stx_cfg_if cfg_ch ();

	int fail_count;
	int pending;

	// Idling control: gap_odds of 0 means no gaps or stalls, otherwise roughly one
	// burst per gap_odds items; no_idle switches both sides to full speed.
	int gap_odds     = 4;
	bit no_idle      = 1'b0;
	int stall_left   = 0;
	int still_cycles = 0;
	int items_sent   = 0;

	// Stimulus-side copy of the registers, used only to build frames and size tick runs
	logic [7:0]  cfg_meas_start, cfg_meas_end, cfg_state_start, cfg_state_end;
	logic [6:0]  cfg_meas_len, cfg_state_len;
	logic [15:0] cfg_timeout;

	// Opening sequence, run with both lengths at 4 and the timeout at 0:
	// action in bit 8, byte in bits 7:0
	logic [8:0] opening_items [25] = '{
		{1'b1, 8'h5A},                                    // tick while hunting
		{1'b0, 8'h00}, {1'b0, 8'hFF},                     // unknown start bytes
		{1'b0, RST_MEAS_START}, 9'h0FF, 9'h001, {1'b0, RST_MEAS_END},  // measure
		{1'b0, RST_MEAS_START}, 9'h000, 9'h000, {1'b0, RST_MEAS_END},  // purge
		{1'b0, RST_STATE_START}, 9'h080, 9'h080, {1'b0, RST_STATE_END}, // state
		{1'b0, RST_MEAS_START}, 9'h012, 9'h0EE, 9'h07F,                // bad end
		{1'b0, RST_STATE_START}, 9'h001, 9'h000, {1'b0, RST_STATE_END}, // bad sum
		{1'b0, RST_MEAS_START}, {1'b1, 8'hA5}                           // timeout
	};

	stx_etx_frame_receiver #(
		.MAX_FRAME(MAX_FRAME)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	stx_frame_monitor #(
		.MAX_FRAME(MAX_FRAME)
	) frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg       (cfg_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Result side: hold ready low in bursts of random length
	always @(posedge clk) begin
		if (no_idle || gap_odds == 0) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if ($urandom_range(1, gap_odds) == 1) begin
			res_ch.ready <= 1'b0;
			stall_left   <= $urandom_range(0, 14);
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog: any transaction on any channel restarts the count
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			still_cycles <= 0;
		end else if (still_cycles >= STILL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			still_cycles <= still_cycles + 1;
		end
	end

	function automatic int clamp_len(input logic [6:0] v);
		if (v < 7'd4)
			return 4;
		if (int'(v) > MAX_FRAME)
			return MAX_FRAME;
		return int'(v);
	endfunction

	// Mostly short frames; now and then any register value, clamped or not
	function automatic logic [6:0] pick_len();
		if ($urandom_range(0, 3) == 0)
			return 7'($urandom_range(0, 127));
		return 7'($urandom_range(4, 20));
	endfunction

	function automatic logic [15:0] pick_timeout();
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom_range(0, 1));
		return 16'($urandom_range(2, 80));
	endfunction

	// Offer one byte or tick and hold it until the transaction completes.
	// An idle burst, if any, goes before the item so valid never drops and rises
	// within one time step.
	task automatic put_item(input logic act, input logic [7:0] val);
		if (!no_idle && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		rx_ch.valid      <= 1'b1;
		rx_ch.action     <= act;
		rx_ch.byte_value <= val;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Write one register; valid stays high so back-to-back writes need no re-arm
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic set_regs(input logic [7:0] ms, me, ss, se, input logic [6:0] ml, sl,
			input logic [15:0] tmo);
		write_reg(REG_MEAS_START, {8'h00, ms});
		write_reg(REG_MEAS_END, {8'h00, me});
		write_reg(REG_STATE_START, {8'h00, ss});
		write_reg(REG_STATE_END, {8'h00, se});
		write_reg(REG_MEAS_LEN, {9'h000, ml});
		write_reg(REG_STATE_LEN, {9'h000, sl});
		write_reg(REG_TIMEOUT, tmo);
		cfg_ch.valid    <= 1'b0;
		cfg_meas_start  = ms;
		cfg_meas_end    = me;
		cfg_state_start = ss;
		cfg_state_end   = se;
		cfg_meas_len    = ml;
		cfg_state_len   = sl;
		cfg_timeout     = tmo;
	endtask

	// Stop offering items, wait for every outstanding result, then let the
	// pipeline empty of items that produce nothing. Sample at the falling edge
	// so the outstanding count is settled.
	task automatic drain();
		rx_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Build one frame for the current settings, optionally broken, and send it
	// with the odd tick mixed in. Equal start codes make every frame a measure one.
	task automatic send_frame(input frame_fault_t fault);
		logic [7:0] fb [MAX_FRAME];
		logic [7:0] lead;
		logic [7:0] sum;
		logic       st;
		int         len;
		int         count;
		int         i;
		st   = 1'($urandom_range(0, 1));
		lead = st ? cfg_state_start : cfg_meas_start;
		st   = (lead != cfg_meas_start);
		len  = clamp_len(st ? cfg_state_len : cfg_meas_len);
		fb[0] = lead;
		for (i = 1; i < len; i++)
			fb[i] = 8'($urandom);
		// Bias measure frames towards standby and purge modes
		if (!st) begin
			case ($urandom_range(0, 3))
				0: for (i = 1; i <= 8 && i < len; i++) fb[i] = 8'h00;
				1: begin
					fb[1] = 8'h00;
					if (len > 2)
						fb[2] = 8'h00;
				end
				default: ;
			endcase
		end
		sum = 8'h00;
		for (i = 1; i <= len - 3; i++)
			sum = sum + fb[i];
		fb[len - 2] = 8'h00 - sum;
		fb[len - 1] = st ? cfg_state_end : cfg_meas_end;
		count = len;
		case (fault)
			FR_BAD_END: fb[len - 1] = fb[len - 1] ^ 8'($urandom_range(1, 255));
			FR_BAD_SUM: fb[len - 2] = fb[len - 2] ^ 8'($urandom_range(1, 255));
			FR_CUT:     count = $urandom_range(1, len - 1);
			default: ;
		endcase
		for (i = 0; i < count; i++) begin
			if (i > 0 && $urandom_range(0, 19) == 0)
				put_item(1'b1, 8'($urandom));
			put_item(1'b0, fb[i]);
		end
	endtask

	// Mostly well-formed frames with random content; the rest broken frames,
	// frames left to time out, stray bytes and stray ticks.
	task automatic run_traffic(input int n);
		int first;
		int pick;
		int lim;
		first = items_sent;
		while (items_sent - first < n) begin
			pick = $urandom_range(0, 19);
			if (pick < 12)
				send_frame(FR_GOOD);
			else if (pick < 14)
				send_frame(FR_BAD_END);
			else if (pick < 16)
				send_frame(FR_BAD_SUM);
			else if (pick < 17)
				send_frame(FR_CUT);
			else if (pick < 18) begin
				lim = (cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout);
				send_frame(FR_CUT);
				if (lim <= TICK_RUN_MAX)
					repeat (lim) put_item(1'b1, 8'($urandom));
			end else if (pick < 19)
				put_item(1'b0, 8'($urandom));
			else
				put_item(1'b1, 8'($urandom));
		end
	endtask

	initial begin
		int k;
		// Drive every input to a known value before the first edge
		arst_n           = 1'b0;
		rx_ch.valid      = 1'b0;
		rx_ch.action     = 1'b0;
		rx_ch.byte_value = 8'h00;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = REG_MEAS_START;
		cfg_ch.data      = 16'h0000;
		res_ch.ready     = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Opening sequence: shortest frames, timeout of zero acting as one
		set_regs(RST_MEAS_START, RST_MEAS_END, RST_STATE_START, RST_STATE_END, 7'd4, 7'd4,
			16'd0);
		for (k = 0; k < 25; k++)
			put_item(opening_items[k][8], opening_items[k][7:0]);
		drain();

		// Reset-value settings
		set_regs(RST_MEAS_START, RST_MEAS_END, RST_STATE_START, RST_STATE_END, RST_MEAS_LEN,
			RST_STATE_LEN, RST_TIMEOUT);
		run_traffic(250);
		drain();

		// Extreme codes, longest frames and the longest timeout. Flush any frame
		// left open with a byte that matches neither start code, open a frame and
		// hold it through a burst of ticks at full speed that stays short of the limit.
		set_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 7'd64, 7'd64, 16'hFFFF);
		gap_odds = 0;
		repeat (MAX_FRAME) put_item(1'b0, 8'h11);
		put_item(1'b0, 8'h00);
		repeat (40) put_item(1'b1, 8'($urandom));
		gap_odds = 8;
		run_traffic(200);
		drain();

		// Equal start codes, lengths clamped from both sides, timeout of one tick
		gap_odds = 3;
		set_regs(8'h55, 8'hAA, 8'h55, 8'h5A, 7'd0, 7'd127, 16'd1);
		run_traffic(150);
		drain();

		// Lengths just outside the legal range
		gap_odds = 12;
		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 7'd3, 7'd65, 16'd2);
		run_traffic(150);
		drain();

		// Random settings, some phases without any idling
		repeat (4) begin
			gap_odds = 4 * $urandom_range(0, 3);
			set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), pick_len(),
				pick_len(), pick_timeout());
			run_traffic(150);
			drain();
		end

		// Last stretch at full speed on both sides
		no_idle = 1'b1;
		set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), pick_len(),
			pick_len(), pick_timeout());
		run_traffic(200);
		drain();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
